// File: rtl/assert_macros.svh
// assertion macros for the key debounce block
// expects clk and rst_n in the scope of the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define KDLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent at the next clock edge
`define KDLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/kdle_pkg.sv
// shared constants, types and event code function for the key debounce block
// no dependencies
package kdle_pkg;

    localparam int KEYS         = 5;
    localparam int FILTER_TICKS = 5;
    localparam int CNT_W        = $clog2(2 * FILTER_TICKS + 1);
    localparam int HOLD_W       = 16;
    localparam int REP_W        = 8;
    localparam int CODE_W       = 4;
    localparam int NSLOT        = 2 * KEYS;
    localparam int SLOT_W       = $clog2(NSLOT);
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_TIME    = 2'd0,
        REG_LONG_MASK    = 2'd1,
        REG_REPEAT_SPEED = 2'd2,
        REG_REPEAT_MASK  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        EVK_DOWN = 2'd1,
        EVK_UP   = 2'd2,
        EVK_LONG = 2'd3
    } evt_kind_t;

    typedef struct packed {
        logic down;
        logic up;
        logic long_ev;
        logic rep;
    } lane_evt_t;

    function automatic logic [CODE_W-1:0] evt_code(input int key, input evt_kind_t kind);
        int full;
        full = 3 * key + int'(kind);
        return full[CODE_W-1:0];
    endfunction

endpackage

// File: rtl/kdle_lane.sv
// one key lane: debounce counter, down state, hold and repeat counters
// depends on kdle_pkg
module kdle_lane
    import kdle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              pressed,
    input  logic              long_en,
    input  logic              rep_en,
    input  logic [HOLD_W-1:0] long_time,
    input  logic [REP_W-1:0]  repeat_speed,
    output lane_evt_t         evt
);

    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              down_reg, down_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [REP_W-1:0]  rep_reg,  rep_next;
    logic [HOLD_W-1:0] hold_inc;
    logic [REP_W-1:0]  rep_inc;

    assign hold_inc = hold_reg + HOLD_W'(1);
    assign rep_inc  = rep_reg + REP_W'(1);

    always_comb
    begin
        cnt_next  = cnt_reg;
        down_next = down_reg;
        hold_next = hold_reg;
        rep_next  = rep_reg;
        evt       = '0;
        if (pressed)
        begin
            if (cnt_reg < CNT_W'(FILTER_TICKS))
            begin
                cnt_next = CNT_W'(FILTER_TICKS);
            end
            else if (cnt_reg < CNT_W'(2 * FILTER_TICKS))
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else
            begin
                if (!down_reg)
                begin
                    down_next = 1'b1;
                    evt.down  = 1'b1;
                end
                if (long_en)
                begin
                    if (hold_reg < long_time)
                    begin
                        hold_next   = hold_inc;
                        evt.long_ev = (hold_inc == long_time);
                    end
                    else if (rep_en)
                    begin
                        if (rep_inc >= repeat_speed)
                        begin
                            rep_next = '0;
                            evt.rep  = 1'b1;
                        end
                        else
                        begin
                            rep_next = rep_inc;
                        end
                    end
                end
            end
        end
        else
        begin
            if (cnt_reg > CNT_W'(FILTER_TICKS))
            begin
                cnt_next = CNT_W'(FILTER_TICKS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
            else if (down_reg)
            begin
                down_next = 1'b0;
                evt.up    = 1'b1;
            end
            hold_next = '0;
            rep_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= CNT_W'(FILTER_TICKS / 2);
            down_reg <= 1'b0;
            hold_reg <= '0;
            rep_reg  <= '0;
        end
        else if (accept)
        begin
            cnt_reg  <= cnt_next;
            down_reg <= down_next;
            hold_reg <= hold_next;
            rep_reg  <= rep_next;
        end
    end

endmodule

// File: rtl/kdle_merge.sv
// merge stage: collects lane events of one tick in key order and drains them
// one transaction per cycle while out_ready is high; depends on kdle_pkg
module kdle_merge
    import kdle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_evt_t         evt [KEYS],
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CODE_W-1:0] out_code,
    output logic              out_last
);

    logic [NSLOT-1:0]  vld_reg, vld_next;
    logic [CODE_W-1:0] code_reg [NSLOT];
    logic [NSLOT-1:0]  new_vld;
    logic [CODE_W-1:0] new_code [NSLOT];
    logic [NSLOT-1:0]  first_oh;
    logic [SLOT_W-1:0] first_idx;
    logic              found;
    logic              load;

    always_comb
    begin
        for (int k = 0; k < KEYS; k++)
        begin
            new_vld[2*k]    = evt[k].down | evt[k].rep | evt[k].up | evt[k].long_ev;
            new_vld[2*k+1]  = evt[k].down & evt[k].long_ev;
            new_code[2*k+1] = evt_code(k, EVK_LONG);
            if (evt[k].down || evt[k].rep)
                new_code[2*k] = evt_code(k, EVK_DOWN);
            else if (evt[k].up)
                new_code[2*k] = evt_code(k, EVK_UP);
            else
                new_code[2*k] = evt_code(k, EVK_LONG);
        end
    end

    always_comb
    begin
        found     = 1'b0;
        first_idx = '0;
        first_oh  = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (vld_reg[i] && !found)
            begin
                found       = 1'b1;
                first_idx   = SLOT_W'(i);
                first_oh[i] = 1'b1;
            end
        end
    end

    assign out_valid = found;
    assign out_code  = code_reg[first_idx];
    assign out_last  = found && ((vld_reg & ~first_oh) == '0);
    assign in_ready  = !found || (out_last && out_ready);
    assign load      = in_valid && in_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
            vld_next = new_vld;
        else if (found && out_ready)
            vld_next = vld_reg & ~first_oh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NSLOT; i++)
                code_reg[i] <= new_code[i];
        end
    end

endmodule

// File: rtl/key_debounce_long_press_events.sv
// Key debounce with long-press and auto-repeat events for five keys. Each input
// transaction is one scan tick; every key lane updates in the cycle the tick is taken,
// and its events go out in key order, one per cycle while m_tready is high, with tlast
// on the last one. A new tick is taken when no event is pending or the last one is taken;
// a tick makes at most ten events, which the single output port drains from the event
// buffer. Configuration writes apply from the next tick.
// depends on kdle_pkg, kdle_lane, kdle_merge and assert_macros.svh
`include "assert_macros.svh"

module key_debounce_long_press_events
    import kdle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [4:0] pressed_mask, rest zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [3:0] event_code, rest zero
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [HOLD_W-1:0] long_time_reg;
    logic [KEYS-1:0]   long_mask_reg;
    logic [REP_W-1:0]  repeat_speed_reg;
    logic [KEYS-1:0]   repeat_mask_reg;
    logic              accept;
    logic [CODE_W-1:0] code;
    lane_evt_t         evt [KEYS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_time_reg    <= HOLD_W'(100);
            long_mask_reg    <= '1;
            repeat_speed_reg <= '0;
            repeat_mask_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LONG_TIME:    long_time_reg    <= cfg_data[HOLD_W-1:0];
                REG_LONG_MASK:    long_mask_reg    <= cfg_data[KEYS-1:0];
                REG_REPEAT_SPEED: repeat_speed_reg <= cfg_data[REP_W-1:0];
                REG_REPEAT_MASK:  repeat_mask_reg  <= cfg_data[KEYS-1:0];
                default: ;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    for (genvar k = 0; k < KEYS; k++)
    begin : g_lane
        kdle_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .accept       (accept),
            .pressed      (s_tdata[k]),
            .long_en      ((long_time_reg != '0) && long_mask_reg[k]),
            .rep_en       ((repeat_speed_reg != '0) && repeat_mask_reg[k]),
            .long_time    (long_time_reg),
            .repeat_speed (repeat_speed_reg),
            .evt          (evt[k])
        );
    end

    kdle_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (code),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(OUT_TDATA_W - CODE_W){1'b0}}, code};

    `KDLE_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with no events pending")
    `KDLE_ASSERT(a_code_nonzero, m_tvalid |-> (m_tdata[CODE_W-1:0] != '0), "event code zero")
    `KDLE_ASSERT_NEXT(a_drained_after_last, m_tvalid && m_tready && m_tlast && !accept, !m_tvalid, "events left after last transaction")

endmodule
